// ===== hw/rtl/scadd_pkg.sv =====
// Shared codes and fixed widths for the sparse column scatter-add unit.
`default_nettype none
package scadd_pkg;

   localparam int CMD_W    = 3;
   localparam int STATUS_W = 3;
   localparam int DOF_IN_W = 13;
   localparam int VALUE_W  = 48;
   localparam int ADDR_W   = 15;
   localparam int WORD_W   = 16;
   localparam int POS_W    = 14;
   localparam int CNT_IN_W = 15;

   localparam logic [CMD_W-1:0] CMD_LOAD_MAP    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_COL    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD_ROW    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ADD_MAPPED  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ADD_DIRECT  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_ADD_CONSTR  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd6;
   localparam logic [CMD_W-1:0] CMD_READ        = 3'd7;

   localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SKIP_CONSTR = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SKIP_LOWER = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DONE       = 3'd4;

   localparam logic CSR_SYMMETRIC = 1'b0;
   localparam logic CSR_ENTRY_CNT = 1'b1;

endpackage
`default_nettype wire

// ===== hw/rtl/sparse_column_scatter_add_unit.sv =====
// Top level of the sparse column scatter-add unit: control sequencer over four table RAMs.
//
//   channel  direction  handshake        payload
//   req      in         valid / stall    cmd, row_dof, col_dof, add_value, table_addr, table_word
//   rsp      out        valid / stall    status, hit_position, read_value
//   csr      in         valid / ready    index, data
//
// One word is processed at a time. An add that reaches the row search compares row indices
// in turn, since the row table RAM is read once per cycle; a mapped add first does the two
// map lookups. A clear zeroes the values one after another, starting at address zero.
// Reset only clears control state; table contents are undefined until loaded or cleared.
// A new word is taken while a finished result still waits under rsp_stall.
`default_nettype none
module sparse_column_scatter_add_unit #(
   parameter int MAX_DOFS     = 4096,
   parameter int MAX_UNKNOWNS = 4096,
   parameter int MAX_NONZEROS = 16384
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [scadd_pkg::CMD_W-1:0]         req_cmd,
   input  wire logic signed [scadd_pkg::DOF_IN_W-1:0] req_row_dof,
   input  wire logic signed [scadd_pkg::DOF_IN_W-1:0] req_col_dof,
   input  wire logic signed [scadd_pkg::VALUE_W-1:0]  req_add_value,
   input  wire logic [scadd_pkg::ADDR_W-1:0]        req_table_addr,
   input  wire logic signed [scadd_pkg::WORD_W-1:0] req_table_word,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [scadd_pkg::STATUS_W-1:0]           rsp_status,
   output logic [scadd_pkg::POS_W-1:0]              rsp_hit_position,
   output logic signed [scadd_pkg::VALUE_W-1:0]     rsp_read_value,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic                                csr_index,
   input  wire logic [scadd_pkg::CNT_IN_W-1:0]      csr_data
);

   localparam int DOF_W = $clog2(MAX_DOFS);
   localparam int UNK_W = $clog2(MAX_UNKNOWNS + 1);
   localparam int NZ_W  = $clog2(MAX_NONZEROS);
   localparam int CNT_W = $clog2(MAX_NONZEROS + 1);
   localparam int VW    = scadd_pkg::VALUE_W;
   localparam int WW    = scadd_pkg::WORD_W;
   localparam int DOF_IN_W_M1 = scadd_pkg::DOF_IN_W - 1;
   localparam int DOF_IN_W_M2 = scadd_pkg::DOF_IN_W - 2;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MAPR    = 4'd1;
   localparam logic [3:0] S_MAPC    = 4'd2;
   localparam logic [3:0] S_COL     = 4'd3;
   localparam logic [3:0] S_CS0     = 4'd4;
   localparam logic [3:0] S_CS1     = 4'd5;
   localparam logic [3:0] S_ROW_RD  = 4'd6;
   localparam logic [3:0] S_ROW_CMP = 4'd7;
   localparam logic [3:0] S_VAL_WR  = 4'd8;
   localparam logic [3:0] S_CLR     = 4'd9;
   localparam logic [3:0] S_RDV     = 4'd10;
   localparam logic [3:0] S_DONE    = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       sym_ff, sym_in;
   logic [scadd_pkg::CNT_IN_W-1:0] count_ff, count_in;

   logic signed [scadd_pkg::DOF_IN_W-1:0] rd_ff, rd_in, cd_ff, cd_in;
   logic signed [VW-1:0] val_ff, val_in;
   logic signed [WW-1:0] row_ff, row_in, col_ff, col_in;
   logic [WW-1:0] start_ff, start_in, stop_ff, stop_in, m_ff, m_in;
   logic [CNT_W-1:0] clr_idx_ff, clr_idx_in, clr_n_ff, clr_n_in;

   logic [scadd_pkg::STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic [scadd_pkg::POS_W-1:0]    pend_pos_ff, pend_pos_in;
   logic [VW-1:0]                  pend_rv_ff, pend_rv_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [scadd_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [scadd_pkg::POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [VW-1:0]                  rsp_rv_ff, rsp_rv_in;

   // RAM ports.
   logic             map_we, cs_we, row_we, vl_we;
   logic [DOF_W-1:0] map_waddr, map_raddr;
   logic [UNK_W-1:0] cs_waddr, cs_raddr;
   logic [NZ_W-1:0]  row_waddr, row_raddr, vl_waddr, vl_raddr;
   logic [WW-1:0]    map_rdata, cs_rdata, row_rdata;
   logic [VW-1:0]    vl_wdata, vl_rdata;

   logic accept;
   logic signed [WW-1:0] map_k;
   logic [WW-1:0] stop_clamped;
   logic [CNT_W-1:0] clear_len;
   logic [UNK_W-1:0] col_addr;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign map_k     = $signed(map_rdata);
   assign col_addr  = UNK_W'(col_ff[WW-2:0]);

   assign stop_clamped = (32'(cs_rdata) > MAX_NONZEROS) ? WW'(MAX_NONZEROS) : cs_rdata;
   assign clear_len = (32'(count_ff) > MAX_NONZEROS) ? CNT_W'(MAX_NONZEROS)
                                                     : CNT_W'(count_ff);

   scadd_ram #(.WIDTH(WW), .DEPTH(MAX_DOFS)) u_map_ram (
      .clock(clock), .we(map_we), .waddr(map_waddr), .wdata(req_table_word),
      .raddr(map_raddr), .rdata(map_rdata)
   );
   scadd_ram #(.WIDTH(WW), .DEPTH(MAX_UNKNOWNS + 1)) u_col_ram (
      .clock(clock), .we(cs_we), .waddr(cs_waddr), .wdata(req_table_word),
      .raddr(cs_raddr), .rdata(cs_rdata)
   );
   scadd_ram #(.WIDTH(WW), .DEPTH(MAX_NONZEROS)) u_row_ram (
      .clock(clock), .we(row_we), .waddr(row_waddr), .wdata(req_table_word),
      .raddr(row_raddr), .rdata(row_rdata)
   );
   scadd_ram #(.WIDTH(VW), .DEPTH(MAX_NONZEROS)) u_val_ram (
      .clock(clock), .we(vl_we), .waddr(vl_waddr), .wdata(vl_wdata),
      .raddr(vl_raddr), .rdata(vl_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      sym_in         = sym_ff;
      count_in       = count_ff;
      rd_in          = rd_ff;
      cd_in          = cd_ff;
      val_in         = val_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      start_in       = start_ff;
      stop_in        = stop_ff;
      m_in           = m_ff;
      clr_idx_in     = clr_idx_ff;
      clr_n_in       = clr_n_ff;
      pend_status_in = pend_status_ff;
      pend_pos_in    = pend_pos_ff;
      pend_rv_in     = pend_rv_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_rv_in      = rsp_rv_ff;

      map_we    = 1'b0;
      cs_we     = 1'b0;
      row_we    = 1'b0;
      vl_we     = 1'b0;
      map_waddr = DOF_W'(req_table_addr);
      cs_waddr  = UNK_W'(req_table_addr);
      row_waddr = NZ_W'(req_table_addr);
      vl_waddr  = NZ_W'(m_ff);
      vl_wdata  = vl_rdata + val_ff;
      map_raddr = DOF_W'(req_row_dof[DOF_IN_W_M2:0]);
      cs_raddr  = col_addr;
      row_raddr = NZ_W'(m_ff);
      vl_raddr  = NZ_W'(req_table_addr);

      if (csr_valid) begin
         if (csr_index == scadd_pkg::CSR_SYMMETRIC) begin
            sym_in = csr_data[0];
         end else begin
            count_in = csr_data;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rd_in          = req_row_dof;
               cd_in          = req_col_dof;
               val_in         = req_add_value;
               row_in         = {{(WW-scadd_pkg::DOF_IN_W){req_row_dof[DOF_IN_W_M1]}},
                                 req_row_dof};
               col_in         = {{(WW-scadd_pkg::DOF_IN_W){req_col_dof[DOF_IN_W_M1]}},
                                 req_col_dof};
               pend_status_in = scadd_pkg::ST_DONE;
               pend_pos_in    = '0;
               pend_rv_in     = '0;
               state_in       = S_DONE;
               case (req_cmd)
                  scadd_pkg::CMD_LOAD_MAP: begin
                     map_we = (32'(req_table_addr) < MAX_DOFS);
                  end
                  scadd_pkg::CMD_LOAD_COL: begin
                     cs_we = (32'(req_table_addr) < MAX_UNKNOWNS + 1);
                  end
                  scadd_pkg::CMD_LOAD_ROW: begin
                     row_we = (32'(req_table_addr) < MAX_NONZEROS);
                  end
                  scadd_pkg::CMD_ADD_MAPPED: begin
                     if (req_row_dof[DOF_IN_W_M1] ||
                         32'(req_row_dof[DOF_IN_W_M2:0]) >= MAX_DOFS) begin
                        pend_status_in = scadd_pkg::ST_SKIP_CONSTR;
                     end else begin
                        state_in = S_MAPR;
                     end
                  end
                  scadd_pkg::CMD_ADD_DIRECT: begin
                     state_in = S_COL;
                  end
                  scadd_pkg::CMD_ADD_CONSTR: begin
                     if (req_row_dof == -13'sd1 || req_col_dof == -13'sd1) begin
                        pend_status_in = scadd_pkg::ST_SKIP_CONSTR;
                     end else if (req_col_dof < req_row_dof) begin
                        pend_status_in = scadd_pkg::ST_SKIP_LOWER;
                     end else begin
                        state_in = S_COL;
                     end
                  end
                  scadd_pkg::CMD_CLEAR: begin
                     clr_idx_in = '0;
                     clr_n_in   = clear_len;
                     if (clear_len != '0) begin
                        state_in = S_CLR;
                     end
                  end
                  default: begin
                     if (32'(req_table_addr) < MAX_NONZEROS) begin
                        state_in = S_RDV;
                     end
                  end
               endcase
            end
         end
         S_MAPR: begin
            // The column dof lookup is issued while the row result is checked.
            map_raddr = DOF_W'(cd_ff[DOF_IN_W_M2:0]);
            state_in  = S_DONE;
            if (map_k < 0) begin
               pend_status_in = scadd_pkg::ST_SKIP_CONSTR;
            end else if (sym_ff && rd_ff > cd_ff) begin
               pend_status_in = scadd_pkg::ST_SKIP_LOWER;
            end else if (cd_ff[DOF_IN_W_M1] ||
                         32'(cd_ff[DOF_IN_W_M2:0]) >= MAX_DOFS) begin
               pend_status_in = scadd_pkg::ST_SKIP_CONSTR;
            end else begin
               row_in   = map_k;
               state_in = S_MAPC;
            end
         end
         S_MAPC: begin
            if (map_k < 0) begin
               pend_status_in = scadd_pkg::ST_SKIP_CONSTR;
               state_in       = S_DONE;
            end else begin
               col_in   = map_k;
               state_in = S_COL;
            end
         end
         S_COL: begin
            if (col_ff[WW-1] || 32'(col_ff[WW-2:0]) >= MAX_UNKNOWNS) begin
               pend_status_in = scadd_pkg::ST_NOT_FOUND;
               state_in       = S_DONE;
            end else begin
               state_in = S_CS0;
            end
         end
         S_CS0: begin
            start_in = cs_rdata;
            cs_raddr = UNK_W'(32'(col_addr) + 1);
            state_in = S_CS1;
         end
         S_CS1: begin
            if (start_ff < stop_clamped) begin
               m_in     = start_ff;
               stop_in  = stop_clamped;
               state_in = S_ROW_RD;
            end else begin
               pend_status_in = scadd_pkg::ST_NOT_FOUND;
               state_in       = S_DONE;
            end
         end
         S_ROW_RD: begin
            state_in = S_ROW_CMP;
         end
         S_ROW_CMP: begin
            // The next row index is fetched ahead, while this one is compared.
            row_raddr = NZ_W'(32'(m_ff) + 1);
            vl_raddr  = NZ_W'(m_ff);
            if ($signed(row_rdata) == row_ff) begin
               state_in = S_VAL_WR;
            end else if (32'(m_ff) + 1 < 32'(stop_ff)) begin
               m_in = WW'(32'(m_ff) + 1);
            end else begin
               pend_status_in = scadd_pkg::ST_NOT_FOUND;
               state_in       = S_DONE;
            end
         end
         S_VAL_WR: begin
            vl_we          = 1'b1;
            pend_status_in = scadd_pkg::ST_ADDED;
            pend_pos_in    = scadd_pkg::POS_W'(m_ff);
            state_in       = S_DONE;
         end
         S_CLR: begin
            vl_we    = 1'b1;
            vl_waddr = clr_idx_ff[NZ_W-1:0];
            vl_wdata = '0;
            if (clr_idx_ff + 1'b1 == clr_n_ff) begin
               state_in = S_DONE;
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end
         S_RDV: begin
            pend_rv_in = vl_rdata;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_pos_in    = pend_pos_ff;
               rsp_rv_in     = pend_rv_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sym_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sym_ff       <= sym_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ff          <= rd_in;
      cd_ff          <= cd_in;
      val_ff         <= val_in;
      row_ff         <= row_in;
      col_ff         <= col_in;
      start_ff       <= start_in;
      stop_ff        <= stop_in;
      m_ff           <= m_in;
      clr_idx_ff     <= clr_idx_in;
      clr_n_ff       <= clr_n_in;
      pend_status_ff <= pend_status_in;
      pend_pos_ff    <= pend_pos_in;
      pend_rv_ff     <= pend_rv_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_rv_ff      <= rsp_rv_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_hit_position = rsp_pos_ff;
   assign rsp_read_value   = rsp_rv_ff;

   // The value RAM is only written by the accumulate step or the clear sweep.
   a_val_write_owner: assert property (@(posedge clock) disable iff (reset)
      vl_we |-> (state_ff == S_VAL_WR || state_ff == S_CLR))
      else $error("value RAM written outside accumulate or clear");

   // The search pointer stays inside the column bounds.
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROW_RD || state_ff == S_ROW_CMP) |-> (m_ff < stop_ff))
      else $error("row search pointer beyond column end");

   // The clear sweep never runs past its length.
   a_clear_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> (clr_idx_ff < clr_n_ff))
      else $error("clear sweep beyond its length");

   // An accumulate always hands an added status to the result stage next.
   a_added_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VAL_WR) |=> (state_ff == S_DONE &&
                                  pend_status_ff == scadd_pkg::ST_ADDED))
      else $error("accumulate did not report added");

endmodule
`default_nettype wire

// ===== hw/rtl/scadd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module scadd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ===== bench/tb_sparse_column_scatter_add_unit.sv =====
// Self-checking testbench for the sparse column scatter-add unit.
`timescale 1ns / 1ps
module tb_sparse_column_scatter_add_unit;

   localparam int NDOF = 4096;
   localparam int NUNK = 4096;
   localparam int NNZ  = 16384;

   // Random traffic mostly stays on a small corner of the tables that is fully loaded.
   localparam int USED_DOFS = 64;
   localparam int USED_UNK  = 16;
   localparam int USED_ROWS = 72;

   typedef struct {
      logic [scadd_pkg::CMD_W-1:0]           cmd;
      logic signed [scadd_pkg::DOF_IN_W-1:0] row_dof;
      logic signed [scadd_pkg::DOF_IN_W-1:0] col_dof;
      logic signed [scadd_pkg::VALUE_W-1:0]  add_value;
      logic [scadd_pkg::ADDR_W-1:0]          table_addr;
      logic signed [scadd_pkg::WORD_W-1:0]   table_word;
   } req_word_type;

   typedef struct {
      logic [scadd_pkg::STATUS_W-1:0] status;
      logic [scadd_pkg::POS_W-1:0]    hit_position;
      logic [scadd_pkg::VALUE_W-1:0]  read_value;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [scadd_pkg::CMD_W-1:0] req_cmd = '0;
   logic signed [scadd_pkg::DOF_IN_W-1:0] req_row_dof = '0;
   logic signed [scadd_pkg::DOF_IN_W-1:0] req_col_dof = '0;
   logic signed [scadd_pkg::VALUE_W-1:0] req_add_value = '0;
   logic [scadd_pkg::ADDR_W-1:0] req_table_addr = '0;
   logic signed [scadd_pkg::WORD_W-1:0] req_table_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [scadd_pkg::STATUS_W-1:0] rsp_status;
   logic [scadd_pkg::POS_W-1:0] rsp_hit_position;
   logic signed [scadd_pkg::VALUE_W-1:0] rsp_read_value;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [scadd_pkg::CNT_IN_W-1:0] csr_data = '0;

   sparse_column_scatter_add_unit u_dut (.*);

   // Shadow copy of the block's tables and registers.
   int            dof_map[NDOF];
   logic [15:0]   col_start[NUNK+1];
   int            entry_row[NNZ];
   logic [47:0]   entry_val[NNZ];
   logic          sym_upper = 1'b0;
   int            clear_len = 0;

   req_word_type pending_words[$];
   rsp_word_type expected_rsp[$];
   req_word_type cur_word;
   int send_idle = 25;
   int recv_idle = 87;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int errors = 0;

   initial forever #2 clock = ~clock;

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [scadd_pkg::STATUS_W-1:0] scatter_add(int row, int col,
         logic [47:0] val, output logic [scadd_pkg::POS_W-1:0] pos);
      int first;
      int last;
      pos = '0;
      if (col < 0 || col >= NUNK) return scadd_pkg::ST_NOT_FOUND;
      first = col_start[col];
      last = col_start[col+1];
      if (last > NNZ) last = NNZ;
      for (int m = first; m < last; m++) begin
         if (entry_row[m] == row) begin
            entry_val[m] = entry_val[m] + val;
            pos = m[scadd_pkg::POS_W-1:0];
            return scadd_pkg::ST_ADDED;
         end
      end
      return scadd_pkg::ST_NOT_FOUND;
   endfunction

   function automatic int map_dof(int dof);
      if (dof < 0 || dof >= NDOF) return -1;
      return dof_map[dof];
   endfunction

   function automatic rsp_word_type predict_rsp(req_word_type w);
      rsp_word_type r;
      int rd;
      int cd;
      int k;
      int l;
      int n;
      rd = w.row_dof;
      cd = w.col_dof;
      r.status = scadd_pkg::ST_DONE;
      r.hit_position = '0;
      r.read_value = '0;
      case (w.cmd)
         scadd_pkg::CMD_LOAD_MAP:
            if (w.table_addr < NDOF) dof_map[w.table_addr] = w.table_word;
         scadd_pkg::CMD_LOAD_COL:
            if (w.table_addr < NUNK + 1) col_start[w.table_addr] = w.table_word;
         scadd_pkg::CMD_LOAD_ROW:
            if (w.table_addr < NNZ) entry_row[w.table_addr] = w.table_word;
         scadd_pkg::CMD_ADD_MAPPED: begin
            k = map_dof(rd);
            if (k < 0) r.status = scadd_pkg::ST_SKIP_CONSTR;
            else if (sym_upper && rd > cd) r.status = scadd_pkg::ST_SKIP_LOWER;
            else begin
               l = map_dof(cd);
               if (l < 0) r.status = scadd_pkg::ST_SKIP_CONSTR;
               else r.status = scatter_add(k, l, w.add_value, r.hit_position);
            end
         end
         scadd_pkg::CMD_ADD_DIRECT:
            r.status = scatter_add(rd, cd, w.add_value, r.hit_position);
         scadd_pkg::CMD_ADD_CONSTR: begin
            if (rd == -1 || cd == -1) r.status = scadd_pkg::ST_SKIP_CONSTR;
            else if (cd < rd) r.status = scadd_pkg::ST_SKIP_LOWER;
            else r.status = scatter_add(rd, cd, w.add_value, r.hit_position);
         end
         scadd_pkg::CMD_CLEAR: begin
            n = (clear_len > NNZ) ? NNZ : clear_len;
            for (int i = 0; i < n; i++) entry_val[i] = '0;
         end
         default: if (w.table_addr < NNZ) r.read_value = entry_val[w.table_addr];
      endcase
      return r;
   endfunction

   // Driver: offers the next pending word, holding it while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_rsp.push_back(predict_rsp(cur_word));
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
               cur_word = pending_words.pop_front();
               req_cmd <= cur_word.cmd;
               req_row_dof <= cur_word.row_dof;
               req_col_dof <= cur_word.col_dof;
               req_add_value <= cur_word.add_value;
               req_table_addr <= cur_word.table_addr;
               req_table_word <= cur_word.table_word;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result and drives the receiver stall.
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_hit_position !== e.hit_position) begin
               $error("hit_position expected %0d actual %0d", e.hit_position,
                      rsp_hit_position);
               errors++;
            end
            if (rsp_read_value !== e.read_value) begin
               $error("read_value expected %h actual %h", e.read_value, rsp_read_value);
               errors++;
            end
         end
      end
      if (hold_seen != hold_token) begin
         hold_seen = hold_token;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   task automatic push_word(logic [scadd_pkg::CMD_W-1:0] cmd, int rd, int cd,
                            logic [47:0] val, int addr, int word);
      req_word_type w;
      w.cmd = cmd;
      w.row_dof = rd[scadd_pkg::DOF_IN_W-1:0];
      w.col_dof = cd[scadd_pkg::DOF_IN_W-1:0];
      w.add_value = val;
      w.table_addr = addr[scadd_pkg::ADDR_W-1:0];
      w.table_word = word[scadd_pkg::WORD_W-1:0];
      pending_words.push_back(w);
   endtask

   task automatic wait_idle();
      while (pending_words.size() != 0 || expected_rsp.size() != 0 || req_valid)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int data);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data[scadd_pkg::CNT_IN_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == scadd_pkg::CSR_SYMMETRIC) sym_upper = data[0];
      else clear_len = data & 32'h7FFF;
   endtask

   function automatic logic [47:0] rand_value();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[47:0];
   endfunction

   function automatic int rand_col();
      if ($urandom_range(9) == 0) return ($urandom_range(1) == 0) ? -1 : NUNK - 1;
      return $urandom_range(USED_UNK - 1);
   endfunction

   function automatic int rand_dof();
      if ($urandom_range(9) == 0) return ($urandom_range(1) == 0) ? -1 : NDOF - 1;
      return $urandom_range(USED_DOFS - 1);
   endfunction

   // Random phase: mostly adds on the small dense corner of the pattern.
   task automatic push_random(int count);
      int sel;
      int a;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(99);
         if (sel < 5) begin
            a = ($urandom_range(9) == 0) ? $urandom_range(NNZ, NDOF)
                                         : $urandom_range(USED_DOFS - 1);
            push_word(scadd_pkg::CMD_LOAD_MAP, 0, 0, rand_value(), a,
                      ($urandom_range(7) == 0) ? $urandom_range(NNZ, NUNK)
                                               : $urandom_range(16) - 1);
         end else if (sel < 9) begin
            a = $urandom_range(USED_UNK);
            if ($urandom_range(9) == 0) begin
               push_word(scadd_pkg::CMD_LOAD_COL, 0, 0, rand_value(),
                         $urandom_range(NNZ, NUNK + 1), 7);
            end else begin
               push_word(scadd_pkg::CMD_LOAD_COL, 0, 0, rand_value(), a,
                         (a * 4 + $urandom_range(6) > 3) ? a * 4 + $urandom_range(6) - 3 : 0);
            end
         end else if (sel < 13) begin
            push_word(scadd_pkg::CMD_LOAD_ROW, 0, 0, rand_value(), $urandom_range(NNZ),
                      ($urandom_range(9) == 0) ? $urandom_range(NNZ + 1) - 1
                                               : $urandom_range(15));
         end else if (sel < 38) begin
            push_word(scadd_pkg::CMD_ADD_MAPPED, rand_dof(), rand_dof(),
                      rand_value(), $urandom_range(NNZ), $urandom());
         end else if (sel < 63) begin
            push_word(scadd_pkg::CMD_ADD_DIRECT,
                      ($urandom_range(9) == 0) ? $urandom_range(NDOF) - 1 : $urandom_range(15),
                      rand_col(), rand_value(), $urandom_range(NNZ), $urandom());
         end else if (sel < 83) begin
            push_word(scadd_pkg::CMD_ADD_CONSTR,
                      ($urandom_range(9) == 0) ? -1 : $urandom_range(15),
                      rand_col(), rand_value(), $urandom_range(NNZ), $urandom());
         end else if (sel < 84) begin
            push_word(scadd_pkg::CMD_CLEAR, 0, 0, rand_value(), 0, 0);
         end else begin
            push_word(scadd_pkg::CMD_READ, 0, 0, rand_value(),
                      ($urandom_range(3) == 0) ? $urandom_range(NNZ) : $urandom_range(63), 0);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_csr(scadd_pkg::CSR_ENTRY_CNT, NNZ);

      // Load every table entry that a search can reach, then clear all values.
      for (int i = 0; i < USED_DOFS; i++)
         push_word(scadd_pkg::CMD_LOAD_MAP, 0, 0, 0, i, (i % 7 == 3) ? -1 : i % 16);
      push_word(scadd_pkg::CMD_LOAD_MAP, 0, 0, 0, NDOF - 1, -1);
      for (int i = 0; i <= USED_UNK; i++)
         push_word(scadd_pkg::CMD_LOAD_COL, 0, 0, 0, i, i * 4);
      push_word(scadd_pkg::CMD_LOAD_COL, 0, 0, 0, NUNK - 1, NNZ - 1);
      push_word(scadd_pkg::CMD_LOAD_COL, 0, 0, 0, NUNK, -1);
      for (int i = 0; i < USED_ROWS; i++)
         push_word(scadd_pkg::CMD_LOAD_ROW, 0, 0, 0, i, $urandom_range(15));
      push_word(scadd_pkg::CMD_LOAD_ROW, 0, 0, 0, NNZ - 1, 4095);
      push_word(scadd_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);

      // Directed corners: table bounds, skip rules, wrap and the clamped search end.
      push_word(scadd_pkg::CMD_READ, 0, 0, 0, NNZ, 0);
      push_word(scadd_pkg::CMD_LOAD_MAP, 0, 0, 0, NDOF, 5);
      push_word(scadd_pkg::CMD_LOAD_COL, 0, 0, 0, NUNK + 1, 5);
      push_word(scadd_pkg::CMD_LOAD_ROW, 0, 0, 0, NNZ, 5);
      push_word(scadd_pkg::CMD_LOAD_ROW, 0, 0, 0, 0, 0);
      push_word(scadd_pkg::CMD_ADD_DIRECT, 0, 0, 48'h7FFF_FFFF_FFFF, 0, 0);
      push_word(scadd_pkg::CMD_ADD_DIRECT, 0, 0, 48'h7FFF_FFFF_FFFF, 0, 0);
      push_word(scadd_pkg::CMD_ADD_DIRECT, 0, 0, 48'h8000_0000_0000, 0, 0);
      push_word(scadd_pkg::CMD_READ, 0, 0, 0, 0, 0);
      push_word(scadd_pkg::CMD_ADD_MAPPED, -1, 0, 1, 0, 0);
      push_word(scadd_pkg::CMD_ADD_MAPPED, 3, 0, 1, 0, 0);
      push_word(scadd_pkg::CMD_ADD_MAPPED, 0, 3, 1, 0, 0);
      push_word(scadd_pkg::CMD_ADD_MAPPED, 4095, 4095, 1, 0, 0);
      push_word(scadd_pkg::CMD_ADD_DIRECT, 4095, -1, 1, 0, 0);
      push_word(scadd_pkg::CMD_ADD_DIRECT, 4095, 4095, 1, 0, 0);
      push_word(scadd_pkg::CMD_ADD_CONSTR, -1, 2, 1, 0, 0);
      push_word(scadd_pkg::CMD_ADD_CONSTR, 2, -1, 1, 0, 0);
      push_word(scadd_pkg::CMD_ADD_CONSTR, 5, 2, 1, 0, 0);
      push_word(scadd_pkg::CMD_LOAD_COL, 0, 0, 0, 10, 100);
      push_word(scadd_pkg::CMD_ADD_DIRECT, 1, 10, 1, 0, 0);
      push_word(scadd_pkg::CMD_LOAD_COL, 0, 0, 0, 10, 40);
      push_word(scadd_pkg::CMD_LOAD_COL, 0, 0, 0, NUNK, -1);
      push_word(scadd_pkg::CMD_LOAD_ROW, 0, 0, 0, NNZ - 1, 4095);
      push_word(scadd_pkg::CMD_ADD_DIRECT, 4095, 4095, 48'hFFFF_FFFF_FFFF, 0, 0);
      push_word(scadd_pkg::CMD_READ, 0, 0, 0, NNZ - 1, 0);

      write_csr(scadd_pkg::CSR_SYMMETRIC, 1);
      write_csr(scadd_pkg::CSR_ENTRY_CNT, 0);
      push_random(210);
      hold_token++;
      push_random(210);

      write_csr(scadd_pkg::CSR_ENTRY_CNT, 32767);
      send_idle = 87;
      recv_idle = 25;
      push_random(420);

      write_csr(scadd_pkg::CSR_SYMMETRIC, 0);
      write_csr(scadd_pkg::CSR_ENTRY_CNT, $urandom_range(200));
      send_idle = 0;
      recv_idle = 0;
      push_random(420);

      wait_idle();
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sparse_column_scatter_add_unit.f =====
hw/rtl/scadd_pkg.sv
hw/rtl/scadd_ram.sv
hw/rtl/sparse_column_scatter_add_unit.sv
bench/tb_sparse_column_scatter_add_unit.sv
